### src/vdt_pkg.sv
`default_nettype none

package vdt_pkg;

    localparam int MAX_VERTICES = 4096;
    // Must be a power of two: the slot is the low bits of the hash.
    localparam int HASH_SLOTS   = 8192;

    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int SLOT_W = $clog2(HASH_SLOTS);
    localparam int VTX_W  = 96;

    localparam logic [31:0] HASH_C1 = 32'h9E3779B1;
    localparam logic [31:0] HASH_C2 = 32'h85EBCA77;
    localparam logic [31:0] HASH_C3 = 32'hC2B2AE3D;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_MAP   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        command;
        logic [31:0] coord_x;
        logic [31:0] coord_y;
        logic [31:0] coord_z;
        logic [11:0] lookup_index;
    } in_t;

    typedef struct packed {
        logic [11:0] unique_index;
        logic        was_new;
        logic        overflow;
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic [12:0] unique_count;
    } out_t;

    // Negative zero is stored and compared as positive zero.
    function automatic logic [31:0] fold_zero(input logic [31:0] w);
        return (w == 32'h8000_0000) ? 32'h0 : w;
    endfunction

    function automatic logic is_nan_word(input logic [31:0] w);
        return ({1'b0, w[30:0]} > 32'h7F80_0000);
    endfunction

endpackage

`default_nettype wire

### src/vdt_ram.sv
`default_nettype none

module vdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/vertex_dedup_table_top.sv
`default_nettype none

// Exact-match vertex welding table. Each add beat carries a vertex as three raw
// IEEE single words; the block returns the dense unique index of that vertex,
// appending it when it has not been seen, and records the mapping from the
// original vertex number to the unique index for the map command. Read returns
// a stored unique vertex and clear empties the block. The block works on one
// beat at a time. An add goes through three hashing states, then probes slots in
// order with a bucket read, bucket check and vertex compare for each occupied
// slot, stopping at an empty slot on a miss, then its decision and result states;
// a NaN add skips the hashing and the probe. Map and read do one memory read, or
// go straight to the result when the index is out of range. After reset and after
// a clear the bucket memory is swept empty, one slot per cycle, during which no
// beat is accepted; the clear result is delivered after that sweep. A finished
// result waits in an output register, so the next beat is accepted while it is
// still pending.

module vertex_dedup_table_top (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire vdt_pkg::in_t  s_payload,
    output logic               m_valid,
    input  wire logic          m_ready,
    output vdt_pkg::out_t      m_payload
);

    import vdt_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_CLEAR  = 11'b000_0000_0010,
        ST_HASH1  = 11'b000_0000_0100,
        ST_HASH2  = 11'b000_0000_1000,
        ST_HASH3  = 11'b000_0001_0000,
        ST_BREAD  = 11'b000_0010_0000,
        ST_BCHK   = 11'b000_0100_0000,
        ST_VCHK   = 11'b000_1000_0000,
        ST_DECIDE = 11'b001_0000_0000,
        ST_LWAIT  = 11'b010_0000_0000,
        ST_RESULT = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Control state.
    logic [CNT_W-1:0]  unique_total_reg, unique_total_next;
    logic [CNT_W-1:0]  orig_total_reg, orig_total_next;
    logic [SLOT_W-1:0] clr_idx_reg, clr_idx_next;
    logic              pend_reg, pend_next;
    logic              m_valid_reg, m_valid_next;

    // Beat being worked on and its partial result.
    cmd_t              cmd_reg, cmd_next;
    logic [31:0]       x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic              nan_reg, nan_next;
    logic [31:0]       h_reg, h_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] probe_cnt_reg, probe_cnt_next;
    logic [IDX_W-1:0]  cand_reg, cand_next;
    logic              hit_reg, hit_next;
    logic              nofree_reg, nofree_next;
    logic [IDX_W-1:0]  found_reg, found_next;
    out_t              res_reg, res_next;
    out_t              out_reg, out_next;

    // Memory ports.
    logic              st_we, bkt_we, o2u_we;
    logic [IDX_W-1:0]  st_waddr, st_raddr, o2u_waddr, o2u_raddr;
    logic [VTX_W-1:0]  st_wdata, st_rdata;
    logic [SLOT_W-1:0] bkt_waddr, bkt_raddr;
    logic [CNT_W-1:0]  bkt_wdata, bkt_rdata, bkt_dec;
    logic [IDX_W-1:0]  o2u_wdata, o2u_rdata;

    logic [31:0]       x_fold, y_fold, z_fold, h3, h_final;
    logic              in_nan;

    // Unique vertex store: x, y and z side by side in one word.
    vdt_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // Hash buckets: zero is empty, otherwise unique index plus one.
    vdt_ram #(.WIDTH(CNT_W), .DEPTH(HASH_SLOTS)) u_bucket (
        .aclk  (aclk),
        .we    (bkt_we),
        .waddr (bkt_waddr),
        .wdata (bkt_wdata),
        .raddr (bkt_raddr),
        .rdata (bkt_rdata)
    );

    // Original vertex number to unique index.
    vdt_ram #(.WIDTH(IDX_W), .DEPTH(MAX_VERTICES)) u_o2u (
        .aclk  (aclk),
        .we    (o2u_we),
        .waddr (o2u_waddr),
        .wdata (o2u_wdata),
        .raddr (o2u_raddr),
        .rdata (o2u_rdata)
    );

    assign x_fold  = fold_zero(s_payload.coord_x);
    assign y_fold  = fold_zero(s_payload.coord_y);
    assign z_fold  = fold_zero(s_payload.coord_z);
    assign in_nan  = is_nan_word(x_fold) || is_nan_word(y_fold) || is_nan_word(z_fold);
    // Last mixing round; its final fold gives the first slot to probe.
    assign h3      = h_reg ^ ((z_reg * HASH_C3) + (h_reg >> 13));
    assign h_final = h3 ^ (h3 >> 16);
    assign bkt_dec = bkt_rdata - CNT_W'(1);

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    always_comb begin
        state_next        = state_reg;
        unique_total_next = unique_total_reg;
        orig_total_next   = orig_total_reg;
        clr_idx_next      = clr_idx_reg;
        pend_next         = pend_reg;
        m_valid_next      = m_valid_reg;
        cmd_next          = cmd_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        z_next            = z_reg;
        nan_next          = nan_reg;
        h_next            = h_reg;
        slot_next         = slot_reg;
        probe_cnt_next    = probe_cnt_reg;
        cand_next         = cand_reg;
        hit_next          = hit_reg;
        nofree_next       = nofree_reg;
        found_next        = found_reg;
        res_next          = res_reg;
        out_next          = out_reg;

        st_we     = 1'b0;
        st_waddr  = unique_total_reg[IDX_W-1:0];
        st_wdata  = {x_reg, y_reg, z_reg};
        st_raddr  = s_payload.lookup_index;
        bkt_we    = 1'b0;
        bkt_waddr = clr_idx_reg;
        bkt_wdata = '0;
        bkt_raddr = slot_reg;
        o2u_we    = 1'b0;
        o2u_waddr = orig_total_reg[IDX_W-1:0];
        o2u_wdata = found_reg;
        o2u_raddr = s_payload.lookup_index;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next    = s_payload.command;
                    x_next      = x_fold;
                    y_next      = y_fold;
                    z_next      = z_fold;
                    nan_next    = in_nan;
                    hit_next    = 1'b0;
                    nofree_next = 1'b0;
                    res_next    = '0;
                    unique case (s_payload.command)
                        CMD_ADD: begin
                            state_next = in_nan ? ST_DECIDE : ST_HASH1;
                        end
                        CMD_MAP: begin
                            if ({1'b0, s_payload.lookup_index} < orig_total_reg) begin
                                state_next = ST_LWAIT;
                            end else begin
                                res_next.overflow = 1'b1;
                                state_next        = ST_RESULT;
                            end
                        end
                        CMD_READ: begin
                            if ({1'b0, s_payload.lookup_index} < unique_total_reg) begin
                                state_next = ST_LWAIT;
                            end else begin
                                res_next.overflow = 1'b1;
                                state_next        = ST_RESULT;
                            end
                        end
                        CMD_CLEAR: begin
                            unique_total_next = '0;
                            orig_total_next   = '0;
                            clr_idx_next      = '0;
                            pend_next         = 1'b1;
                            state_next        = ST_CLEAR;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                bkt_we = 1'b1;
                if (clr_idx_reg == SLOT_W'(HASH_SLOTS - 1)) begin
                    state_next = pend_reg ? ST_RESULT : ST_IDLE;
                end else begin
                    clr_idx_next = clr_idx_reg + SLOT_W'(1);
                end
            end
            ST_HASH1: begin
                h_next     = x_reg * HASH_C1;
                state_next = ST_HASH2;
            end
            ST_HASH2: begin
                h_next     = h_reg ^ ((y_reg * HASH_C2) + (h_reg >> 15));
                state_next = ST_HASH3;
            end
            ST_HASH3: begin
                slot_next      = h_final[SLOT_W-1:0];
                probe_cnt_next = '0;
                state_next     = ST_BREAD;
            end
            ST_BREAD: begin
                state_next = ST_BCHK;
            end
            ST_BCHK: begin
                if (bkt_rdata == '0) begin
                    state_next = ST_DECIDE;
                end else begin
                    st_raddr   = bkt_dec[IDX_W-1:0];
                    cand_next  = bkt_dec[IDX_W-1:0];
                    state_next = ST_VCHK;
                end
            end
            ST_VCHK: begin
                if (st_rdata == {x_reg, y_reg, z_reg}) begin
                    hit_next   = 1'b1;
                    found_next = cand_reg;
                    state_next = ST_DECIDE;
                end else if (probe_cnt_reg == SLOT_W'(HASH_SLOTS - 1)) begin
                    nofree_next = 1'b1;
                    state_next  = ST_DECIDE;
                end else begin
                    slot_next      = slot_reg + SLOT_W'(1);
                    probe_cnt_next = probe_cnt_reg + SLOT_W'(1);
                    state_next     = ST_BREAD;
                end
            end
            ST_DECIDE: begin
                priority if (orig_total_reg >= CNT_W'(MAX_VERTICES)) begin
                    res_next.overflow     = 1'b1;
                    res_next.unique_index = hit_reg ? found_reg : '0;
                end else if (hit_reg) begin
                    o2u_we                = 1'b1;
                    o2u_wdata             = found_reg;
                    orig_total_next       = orig_total_reg + CNT_W'(1);
                    res_next.unique_index = found_reg;
                end else if (unique_total_reg >= CNT_W'(MAX_VERTICES) ||
                             (!nan_reg && nofree_reg)) begin
                    res_next.overflow = 1'b1;
                end else begin
                    st_we                 = 1'b1;
                    bkt_we                = !nan_reg;
                    bkt_waddr             = slot_reg;
                    bkt_wdata             = unique_total_reg + CNT_W'(1);
                    o2u_we                = 1'b1;
                    o2u_wdata             = unique_total_reg[IDX_W-1:0];
                    unique_total_next     = unique_total_reg + CNT_W'(1);
                    orig_total_next       = orig_total_reg + CNT_W'(1);
                    res_next.unique_index = unique_total_reg[IDX_W-1:0];
                    res_next.was_new      = 1'b1;
                end
                state_next = ST_RESULT;
            end
            ST_LWAIT: begin
                if (cmd_reg == CMD_MAP) begin
                    res_next.unique_index = o2u_rdata;
                end else begin
                    res_next.out_x = st_rdata[95:64];
                    res_next.out_y = st_rdata[63:32];
                    res_next.out_z = st_rdata[31:0];
                end
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next              = res_reg;
                    out_next.unique_count = unique_total_reg;
                    m_valid_next          = 1'b1;
                    pend_next             = 1'b0;
                    state_next            = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            unique_total_reg <= '0;
            orig_total_reg   <= '0;
            clr_idx_reg      <= '0;
            pend_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            unique_total_reg <= unique_total_next;
            orig_total_reg   <= orig_total_next;
            clr_idx_reg      <= clr_idx_next;
            pend_reg         <= pend_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        z_reg         <= z_next;
        nan_reg       <= nan_next;
        h_reg         <= h_next;
        slot_reg      <= slot_next;
        probe_cnt_reg <= probe_cnt_next;
        cand_reg      <= cand_next;
        hit_reg       <= hit_next;
        nofree_reg    <= nofree_next;
        found_reg     <= found_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

`ifndef SYNTH
    // No beat may enter while the bucket sweep is running.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("beat accepted during bucket sweep");

    // Every unique vertex came from at least one original vertex.
    a_totals_order: assert property (@(posedge aclk) disable iff (!aresetn)
        unique_total_reg <= orig_total_reg)
        else $error("unique total exceeds original total");

    a_new_not_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(out_reg.was_new && out_reg.overflow))
        else $error("result both new and overflowed");

    // A new entry is always the last one appended.
    a_new_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.was_new) |->
            ({1'b0, out_reg.unique_index} == out_reg.unique_count - CNT_W'(1)))
        else $error("new index is not the last unique entry");
`endif

endmodule

`default_nettype wire
